// ===== hdl/scancode_to_ascii_translator_core_defines.svh =====
// Assertion macros for the scancode translator core.
// Every macro samples on the rising edge of aclk and is disabled while aresetn is low.
// Define ASSERT_OFF to compile all of them away.
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_CORE_DEFINES_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define S2A_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define S2A_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`define S2A_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define S2A_ASSERT(label, prop, msg)
`define S2A_ASSERT_IMPL(label, pre, post, msg)
`define S2A_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== hdl/s2a_pkg.sv =====
`timescale 1ns / 1ps

package s2a_pkg;

    localparam logic [7:0] CODE_LSHIFT = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT = 8'h36;
    localparam logic [7:0] CODE_CAPS   = 8'h3A;
    localparam logic [7:0] CODE_PREFIX = 8'hE0;
    localparam logic [7:0] RELEASE_BIT = 8'h80;
    localparam logic [7:0] CODE_UP     = 8'h48;
    localparam logic [7:0] CODE_DOWN   = 8'h50;
    localparam logic [7:0] CODE_LEFT   = 8'h4B;
    localparam logic [7:0] CODE_RIGHT  = 8'h4D;
    localparam logic [7:0] CODE_BKSP   = 8'h0E;
    localparam logic [7:0] CODE_ENTER  = 8'h1C;

    localparam logic [7:0] CHAR_NONE   = 8'h00;
    localparam logic [7:0] CHAR_UP     = 8'hF1;
    localparam logic [7:0] CHAR_DOWN   = 8'hF2;
    localparam logic [7:0] CHAR_LEFT   = 8'hF3;
    localparam logic [7:0] CHAR_RIGHT  = 8'hF4;
    localparam logic [7:0] CHAR_BKSP   = 8'h08;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    typedef struct packed {
        logic shift_held;
        logic caps_on;
        logic prefix_seen;
    } kbd_flags_t;

    function automatic logic [7:0] rom_plain(input logic [6:0] idx);
        logic [7:0] c;
        case (idx)
            7'h01: c = 8'h1B;
            7'h02: c = 8'h31;
            7'h03: c = 8'h32;
            7'h04: c = 8'h33;
            7'h05: c = 8'h34;
            7'h06: c = 8'h35;
            7'h07: c = 8'h36;
            7'h08: c = 8'h37;
            7'h09: c = 8'h38;
            7'h0A: c = 8'h39;
            7'h0B: c = 8'h30;
            7'h0C: c = 8'h2D;
            7'h0D: c = 8'h3D;
            7'h0E: c = 8'h08;
            7'h0F: c = 8'h09;
            7'h10: c = 8'h71;
            7'h11: c = 8'h77;
            7'h12: c = 8'h65;
            7'h13: c = 8'h72;
            7'h14: c = 8'h74;
            7'h15: c = 8'h79;
            7'h16: c = 8'h75;
            7'h17: c = 8'h69;
            7'h18: c = 8'h6F;
            7'h19: c = 8'h70;
            7'h1A: c = 8'h5B;
            7'h1B: c = 8'h5D;
            7'h1C: c = 8'h0A;
            7'h1E: c = 8'h61;
            7'h1F: c = 8'h73;
            7'h20: c = 8'h64;
            7'h21: c = 8'h66;
            7'h22: c = 8'h67;
            7'h23: c = 8'h68;
            7'h24: c = 8'h6A;
            7'h25: c = 8'h6B;
            7'h26: c = 8'h6C;
            7'h27: c = 8'h3B;
            7'h28: c = 8'h27;
            7'h29: c = 8'h60;
            7'h2B: c = 8'h5C;
            7'h2C: c = 8'h7A;
            7'h2D: c = 8'h78;
            7'h2E: c = 8'h63;
            7'h2F: c = 8'h76;
            7'h30: c = 8'h62;
            7'h31: c = 8'h6E;
            7'h32: c = 8'h6D;
            7'h33: c = 8'h2C;
            7'h34: c = 8'h2E;
            7'h35: c = 8'h2F;
            7'h37: c = 8'h2A;
            7'h39: c = 8'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rom_shift(input logic [6:0] idx);
        logic [7:0] c;
        case (idx)
            7'h01: c = 8'h1B;
            7'h02: c = 8'h21;
            7'h03: c = 8'h40;
            7'h04: c = 8'h23;
            7'h05: c = 8'h24;
            7'h06: c = 8'h25;
            7'h07: c = 8'h5E;
            7'h08: c = 8'h26;
            7'h09: c = 8'h2A;
            7'h0A: c = 8'h28;
            7'h0B: c = 8'h29;
            7'h0C: c = 8'h5F;
            7'h0D: c = 8'h2B;
            7'h0E: c = 8'h08;
            7'h0F: c = 8'h09;
            7'h10: c = 8'h51;
            7'h11: c = 8'h57;
            7'h12: c = 8'h45;
            7'h13: c = 8'h52;
            7'h14: c = 8'h54;
            7'h15: c = 8'h59;
            7'h16: c = 8'h55;
            7'h17: c = 8'h49;
            7'h18: c = 8'h4F;
            7'h19: c = 8'h50;
            7'h1A: c = 8'h7B;
            7'h1B: c = 8'h7D;
            7'h1C: c = 8'h0A;
            7'h1E: c = 8'h41;
            7'h1F: c = 8'h53;
            7'h20: c = 8'h44;
            7'h21: c = 8'h46;
            7'h22: c = 8'h47;
            7'h23: c = 8'h48;
            7'h24: c = 8'h4A;
            7'h25: c = 8'h4B;
            7'h26: c = 8'h4C;
            7'h27: c = 8'h3A;
            7'h28: c = 8'h22;
            7'h29: c = 8'h7E;
            7'h2B: c = 8'h7C;
            7'h2C: c = 8'h5A;
            7'h2D: c = 8'h58;
            7'h2E: c = 8'h43;
            7'h2F: c = 8'h56;
            7'h30: c = 8'h42;
            7'h31: c = 8'h4E;
            7'h32: c = 8'h4D;
            7'h33: c = 8'h3C;
            7'h34: c = 8'h3E;
            7'h35: c = 8'h3F;
            7'h37: c = 8'h2A;
            7'h39: c = 8'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/s2a_xlate.sv =====
`timescale 1ns / 1ps

module s2a_xlate
    import s2a_pkg::*;
(
    input  logic [7:0] scan_byte,
    input  kbd_flags_t flags_cur,
    output kbd_flags_t flags_next,
    output logic [7:0] char_next
);

    logic [7:0] rom_char;
    logic       is_letter;

    always_comb begin
        rom_char  = flags_cur.shift_held ? rom_shift(scan_byte[6:0]) : rom_plain(scan_byte[6:0]);
        is_letter = ((rom_char >= 8'h61) && (rom_char <= 8'h7A))
                 || ((rom_char >= 8'h41) && (rom_char <= 8'h5A));
    end

    always_comb begin
        flags_next = flags_cur;
        char_next  = CHAR_NONE;
        if ((scan_byte == CODE_LSHIFT) || (scan_byte == CODE_RSHIFT)) begin
            flags_next.shift_held = 1'b1;
        end else if ((scan_byte == (CODE_LSHIFT | RELEASE_BIT))
                  || (scan_byte == (CODE_RSHIFT | RELEASE_BIT))) begin
            flags_next.shift_held = 1'b0;
        end else if (scan_byte == CODE_CAPS) begin
            flags_next.caps_on = !flags_cur.caps_on;
        end else if (scan_byte == CODE_PREFIX) begin
            flags_next.prefix_seen = 1'b1;
        end else if (flags_cur.prefix_seen) begin
            flags_next.prefix_seen = 1'b0;
            case (scan_byte)
                CODE_UP:    char_next = CHAR_UP;
                CODE_DOWN:  char_next = CHAR_DOWN;
                CODE_LEFT:  char_next = CHAR_LEFT;
                CODE_RIGHT: char_next = CHAR_RIGHT;
                default:    char_next = CHAR_NONE;
            endcase
        end else if ((scan_byte & RELEASE_BIT) != 8'h00) begin
            char_next = CHAR_NONE;
        end else if (scan_byte == CODE_BKSP) begin
            char_next = CHAR_BKSP;
        end else if (scan_byte == CODE_ENTER) begin
            char_next = CHAR_LF;
        end else if (flags_cur.caps_on && is_letter) begin
            // flip letter case under caps lock
            char_next = rom_char ^ CASE_BIT;
        end else begin
            char_next = rom_char;
        end
    end

endmodule

// ===== hdl/scancode_to_ascii_translator_core.sv =====
// Set-1 keyboard scancode to character translator.
// Input channel s_valid/s_ready/s_scan_byte carries one raw scancode byte per
// request. Output channel m_valid/m_ready/m_char_code/m_has_char carries one
// result per request, in order: the character code (0xF1-0xF4 for up, down,
// left and right arrows, 0 for none) and a flag that the code is nonzero.
// Path: a byte accepted into the input register is translated by the table
// lookup and flag update and registered in the output register.
// Throughput: one request per cycle while m_ready is high, set by the single
// input and output register pair; a new byte is taken while a result waits.
// Shift, caps lock and extended-prefix flags update as each byte moves from
// the input register to the output register.
// Reset (aresetn low, synchronous) clears the flags and both valid bits.
// When m_ready is low the result holds; the input register keeps its byte and
// s_ready drops once it is full, so no request is lost or repeated.
`timescale 1ns / 1ps
`include "scancode_to_ascii_translator_core_defines.svh"

module scancode_to_ascii_translator_core
    import s2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_code,
    output logic       m_has_char
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [7:0] char_reg;
    logic       has_char_reg;
    kbd_flags_t flags_reg;
    kbd_flags_t flags_next;
    logic [7:0] char_next;
    logic       out_advance;
    logic       fire;

    assign out_advance = !out_valid_reg || m_ready;
    assign s_ready     = !in_valid_reg || out_advance;
    assign fire        = in_valid_reg && out_advance;

    s2a_xlate u_xlate (
        .scan_byte  (in_byte_reg),
        .flags_cur  (flags_reg),
        .flags_next (flags_next),
        .char_next  (char_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_scan_byte;
        end
        if (fire) begin
            char_reg     <= char_next;
            has_char_reg <= (char_next != CHAR_NONE);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_char_code = char_reg;
    assign m_has_char  = has_char_reg;

    `S2A_ASSERT_IMPL(a_has_char_match, m_valid, m_has_char == (m_char_code != CHAR_NONE), "has_char disagrees with char_code")
    `S2A_ASSERT_NEXT(a_caps_toggle, fire && (in_byte_reg == CODE_CAPS), flags_reg.caps_on != $past(flags_reg.caps_on), "caps lock did not toggle")
    `S2A_ASSERT_IMPL(a_high_code_arrow, m_valid && (m_char_code[7:4] == 4'hF), (m_char_code >= CHAR_UP) && (m_char_code <= CHAR_RIGHT), "unexpected high character code")
    `S2A_ASSERT(a_ready_when_empty, in_valid_reg || s_ready, "input stalled while input register empty")

endmodule

// ===== tb/sv/scancode_to_ascii_translator_core_tb.sv =====
`timescale 1ns / 1ps

module scancode_to_ascii_translator_core_tb;
    import s2a_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TYPING_SCANS  = 1000;
    localparam int NOISE_SCANS   = 300;
    localparam int REPORT_LIMIT  = 40;
    localparam int SETTLE_CYCLES = 10;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_char_code;
    logic       m_has_char;

    logic [7:0] char_queue[$];
    logic       kb_shift  = 1'b0;
    logic       kb_caps   = 1'b0;
    logic       kb_prefix = 1'b0;
    logic       valid_held = 1'b0;
    int         burst_left = 0;
    int         scans_sent = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    scancode_to_ascii_translator_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_scan_byte (s_scan_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_has_char  (m_has_char)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] key_char(input logic [5:0] idx, input logic shifted);
        logic [0:63][7:0] plain;
        logic [0:63][7:0] upper;
        plain = {
            64'h001B313233343536, 64'h373839302D3D0809,
            64'h7177657274797569, 64'h6F705B5D0A006173,
            64'h646667686A6B6C3B, 64'h2760005C7A786376,
            64'h626E6D2C2E2F002A, 64'h0020000000000000
        };
        upper = {
            64'h001B21402324255E, 64'h262A28295F2B0809,
            64'h5157455254595549, 64'h4F507B7D0A004153,
            64'h444647484A4B4C3A, 64'h227E007C5A584356,
            64'h424E4D3C3E3F002A, 64'h0020000000000000
        };
        return shifted ? upper[idx] : plain[idx];
    endfunction

    function automatic logic [7:0] next_char(input logic [7:0] code);
        logic [7:0] c;
        c = CHAR_NONE;
        if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            kb_shift = 1'b1;
        end else if (code == (CODE_LSHIFT | RELEASE_BIT) ||
                     code == (CODE_RSHIFT | RELEASE_BIT)) begin
            kb_shift = 1'b0;
        end else if (code == CODE_CAPS) begin
            kb_caps = ~kb_caps;
        end else if (code == CODE_PREFIX) begin
            kb_prefix = 1'b1;
        end else if (kb_prefix) begin
            kb_prefix = 1'b0;
            case (code)
                CODE_UP:    c = CHAR_UP;
                CODE_DOWN:  c = CHAR_DOWN;
                CODE_LEFT:  c = CHAR_LEFT;
                CODE_RIGHT: c = CHAR_RIGHT;
                default:    c = CHAR_NONE;
            endcase
        end else if ((code & RELEASE_BIT) != 8'h00) begin
            c = CHAR_NONE;
        end else if (code == CODE_BKSP) begin
            c = CHAR_BKSP;
        end else if (code == CODE_ENTER) begin
            c = CHAR_LF;
        end else begin
            if (!code[6])
                c = key_char(code[5:0], kb_shift);
            if (kb_caps && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
                c = c ^ CASE_BIT;
        end
        return c;
    endfunction

    task automatic send_scan(input logic [7:0] code);
        int gap;
        s_valid     <= 1'b1;
        s_scan_byte <= code;
        valid_held  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        char_queue.push_back(next_char(code));
        scans_sent++;
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid    <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_all_chars();
        if (valid_held) begin
            s_valid    <= 1'b0;
            valid_held = 1'b0;
        end
        while (char_queue.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : sink_pattern
        int mode;
        int seg;
        int period;
        int k;
        forever begin
            mode   = $urandom_range(0, 2);
            seg    = $urandom_range(20, 200);
            period = $urandom_range(2, 8);
            for (k = 0; k < seg; k++) begin
                @(posedge aclk);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ((k % period) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : char_check
        logic [7:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (char_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, got char %02h has %0b",
                             $time, m_char_code, m_has_char);
            end else begin
                want = char_queue.pop_front();
                if (m_char_code !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: char_code expected %02h, got %02h",
                                 $time, want, m_char_code);
                end
                if (m_has_char !== (want != CHAR_NONE)) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: has_char expected %0b, got %0b",
                                 $time, want != CHAR_NONE, m_has_char);
                end
            end
        end
    end

    task automatic test_plain_keys();
        send_scan(8'h00);
        send_scan(8'hFF);
        send_scan(CODE_BKSP);
        send_scan(CODE_ENTER);
    endtask

    task automatic test_modifier_keys();
        send_scan(CODE_LSHIFT);
        send_scan(8'h1E);
        send_scan(CODE_CAPS);
        send_scan(8'h1E);
        send_scan(CODE_LSHIFT | RELEASE_BIT);
        send_scan(8'h1E);
        send_scan(CODE_RSHIFT);
        send_scan(8'h02);
        send_scan(CODE_RSHIFT | RELEASE_BIT);
        send_scan(CODE_CAPS);
    endtask

    task automatic test_extended_keys();
        send_scan(CODE_PREFIX);
        send_scan(CODE_UP);
        send_scan(CODE_PREFIX);
        send_scan(CODE_DOWN);
        send_scan(CODE_PREFIX);
        send_scan(CODE_LEFT);
        send_scan(CODE_PREFIX);
        send_scan(CODE_RIGHT);
        // modifiers after the prefix act on their flag and keep it pending
        send_scan(CODE_PREFIX);
        send_scan(CODE_LSHIFT);
        send_scan(CODE_CAPS);
        send_scan(CODE_RIGHT);
        send_scan(CODE_LSHIFT | RELEASE_BIT);
        send_scan(CODE_CAPS);
    endtask

    task automatic send_extended();
        logic [7:0] code;
        case ($urandom_range(0, 5))
            0:       code = CODE_UP;
            1:       code = CODE_DOWN;
            2:       code = CODE_LEFT;
            3:       code = CODE_RIGHT;
            4:       code = 8'($urandom_range(0, 255));
            default: code = CODE_UP | RELEASE_BIT;
        endcase
        send_scan(CODE_PREFIX);
        send_scan(code);
    endtask

    task automatic test_random_typing();
        int start;
        int pick;
        logic [7:0] key;
        start = scans_sent;
        while (scans_sent - start < TYPING_SCANS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                key = 8'($urandom_range(1, 8'h39));
                send_scan(key);
                if ($urandom_range(0, 2) != 0)
                    send_scan(key | RELEASE_BIT);
            end else if (pick < 62) begin
                key = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
                send_scan($urandom_range(0, 1) ? key : (key | RELEASE_BIT));
            end else if (pick < 68) begin
                send_scan(CODE_CAPS);
            end else if (pick < 85) begin
                send_extended();
            end else if (pick < 92) begin
                key = 8'($urandom_range(8'h3B, 8'h7F));
                send_scan(key);
            end else begin
                key = 8'($urandom_range(0, 255));
                send_scan(key);
            end
        end
        wait_for_all_chars();
    endtask

    task automatic test_random_noise();
        int start;
        logic [7:0] key;
        start = scans_sent;
        while (scans_sent - start < NOISE_SCANS) begin
            if ($urandom_range(0, 7) == 0)
                key = CODE_PREFIX;
            else
                key = 8'($urandom_range(0, 255));
            send_scan(key);
        end
        wait_for_all_chars();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_keys();
        test_modifier_keys();
        test_extended_keys();
        wait_for_all_chars();
        test_random_typing();
        test_random_noise();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
